// ===== rtl/mlpd_pkg.sv =====
// Package for the multi-level long-press detector.
// Holds widths, register indexes and the configuration, state and result types.
// Used by mlpd_core and multi_level_long_press_detector_unit.
package mlpd_pkg;

  localparam int unsigned MaxThresholds = 5;
  localparam int unsigned TimeWidth     = 24;
  localparam int unsigned LevelWidth    = 3;
  localparam int unsigned CountWidth    = 3;
  localparam int unsigned AlarmWidth    = 16;
  localparam int unsigned CfgIdxWidth   = 3;
  localparam int unsigned CfgDataWidth  = 24;
  localparam int unsigned InDataWidth   = 8;
  localparam int unsigned OutDataWidth  = 32;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxWidth-1:0] RegActiveLevel    = 3'd0;
  localparam logic [CfgIdxWidth-1:0] RegThresholdCount = 3'd1;
  localparam logic [CfgIdxWidth-1:0] RegAlarmInterval  = 3'd2;
  localparam logic [CfgIdxWidth-1:0] RegThresholdFirst = 3'd3;
  localparam logic [CfgIdxWidth-1:0] RegThresholdSecond = 3'd4;
  localparam logic [CfgIdxWidth-1:0] RegThresholdThird = 3'd5;
  localparam logic [CfgIdxWidth-1:0] RegThresholdFourth = 3'd6;
  localparam logic [CfgIdxWidth-1:0] RegThresholdFifth = 3'd7;

  localparam logic [TimeWidth-1:0]  TimeMax  = {TimeWidth{1'b1}};
  localparam logic [AlarmWidth-1:0] AlarmMax = {AlarmWidth{1'b1}};

  typedef struct packed {
    logic                                     active_level;
    logic [CountWidth-1:0]                    threshold_count;
    logic [AlarmWidth-1:0]                    alarm_interval;
    logic [MaxThresholds-1:0][TimeWidth-1:0]  thresholds;
  } cfg_t;

  typedef struct packed {
    logic                  last_pin_level;
    logic                  press_running;
    logic [TimeWidth-1:0]  press_timer;
    logic [TimeWidth-1:0]  duration_hold;
    logic [LevelWidth-1:0] level_reached;
    logic                  max_flag;
    logic [LevelWidth-1:0] last_notified_level;
    logic [AlarmWidth-1:0] alarm_timer;
  } state_t;

  // Packed so that pressed sits in the lowest bit of the output tdata.
  typedef struct packed {
    logic                  alarm_beep;
    logic                  level_beep;
    logic                  max_reached;
    logic [LevelWidth-1:0] press_level;
    logic [TimeWidth-1:0]  press_duration;
    logic                  released;
    logic                  pressed;
  } result_t;

endpackage

// ===== rtl/multi_level_long_press_detector_unit.sv =====
// Top level of the multi-level long-press detector.
// Holds configuration, press state and the output register with skid stage;
// depends on mlpd_pkg and mlpd_core.
//
// Usage: each request on the slave stream is one millisecond tick, with the
// sampled button pin level in s_axis_tdata bit 0. Every tick yields exactly one
// result request on the master stream carrying pressed, released, the last
// press duration, the press level, the max flag and the two beep pulses.
// The configuration port writes one register per cycle with cfg_we_i high;
// it is meant to be used only while no tick is outstanding.
// A tick accepted at a clock edge is stored in the output register, or in the
// skid register while a result waits there. One tick per cycle is taken while
// the receiver keeps up, set by the combinational state update in mlpd_core.
// When the receiver stalls, the first result waits in the output register and
// one further tick is still accepted into the skid register; s_axis_tready
// then falls until the output register has been emptied.
// Reset (rst_ni low, asynchronous) restores the default configuration, sets
// the remembered pin level to the idle pull-up level and empties both result
// registers.
module multi_level_long_press_detector_unit import mlpd_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_index_i,
  input  logic [CfgDataWidth-1:0] cfg_wdata_i,
  // Tick stream in.
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // Fields from bit 0: pin_level[0], zero padding [7:1].
  input  logic [InDataWidth-1:0]  s_axis_tdata,
  // Result stream out.
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // Fields from bit 0: pressed[0], released[1], press_duration[25:2],
  // press_level[28:26], max_reached[29], level_beep[30], alarm_beep[31].
  output logic [OutDataWidth-1:0] m_axis_tdata
);

  cfg_t    cfg_q;
  state_t  state_q;
  state_t  state_d;
  result_t result_d;
  result_t out_q;
  result_t skid_q;
  logic    out_valid_q;
  logic    skid_valid_q;
  logic    in_fire;
  logic    out_fire;

  assign s_axis_tready = !skid_valid_q;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_fire      = out_valid_q && m_axis_tready;

  // Configuration registers; each write is truncated to the register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level    <= 1'b0;
      cfg_q.threshold_count <= CountWidth'(3);
      cfg_q.alarm_interval  <= AlarmWidth'(2000);
      cfg_q.thresholds[0]   <= TimeWidth'(50);
      cfg_q.thresholds[1]   <= TimeWidth'(1000);
      cfg_q.thresholds[2]   <= TimeWidth'(3000);
      cfg_q.thresholds[3]   <= TimeWidth'(5000);
      cfg_q.thresholds[4]   <= TimeWidth'(8000);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegActiveLevel:     cfg_q.active_level    <= cfg_wdata_i[0];
        RegThresholdCount:  cfg_q.threshold_count <= cfg_wdata_i[CountWidth-1:0];
        RegAlarmInterval:   cfg_q.alarm_interval  <= cfg_wdata_i[AlarmWidth-1:0];
        RegThresholdFirst:  cfg_q.thresholds[0]   <= cfg_wdata_i[TimeWidth-1:0];
        RegThresholdSecond: cfg_q.thresholds[1]   <= cfg_wdata_i[TimeWidth-1:0];
        RegThresholdThird:  cfg_q.thresholds[2]   <= cfg_wdata_i[TimeWidth-1:0];
        RegThresholdFourth: cfg_q.thresholds[3]   <= cfg_wdata_i[TimeWidth-1:0];
        RegThresholdFifth:  cfg_q.thresholds[4]   <= cfg_wdata_i[TimeWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  mlpd_core u_core (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .pin_level_i (s_axis_tdata[0]),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // Press state advances only on an accepted tick.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{
        last_pin_level:      1'b1,
        press_running:       1'b0,
        press_timer:         '0,
        duration_hold:       '0,
        level_reached:       '0,
        max_flag:            1'b0,
        last_notified_level: '0,
        alarm_timer:         '0
      };
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  // Output register plus skid register. While the skid register is full no
  // tick is taken, so it only ever drains into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (!out_valid_q || out_fire) begin
        out_q <= result_d;
      end else begin
        skid_q <= result_d;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  // The skid register is filled only behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  // A stalled input side always means a result is waiting downstream.
  a_ready_low_only_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (out_valid_q && skid_valid_q))
    else $error("input side stalled without two results waiting");

  // A release tick never reports a running press.
  a_release_not_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.released && out_q.pressed))
    else $error("result reports release and press together");

  // The alarm only sounds at the max level of a running press.
  a_alarm_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.alarm_beep) |-> (out_q.max_reached && out_q.pressed))
    else $error("alarm beep outside max level of a press");

endmodule

// ===== rtl/mlpd_core.sv =====
// Per-tick update of the long-press detector: next state and result of one tick.
// Purely combinational; depends on mlpd_pkg.
module mlpd_core import mlpd_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  logic    pin_level_i,
  output state_t  state_o,
  output result_t result_o
);

  logic [CountWidth-1:0] count_in_use;
  logic [LevelWidth-1:0] found;
  logic                  at_active;
  logic                  pressed;
  logic                  released;
  logic                  skip_level;
  logic                  level_beep;
  logic                  alarm_beep;
  state_t                s;

  // A threshold count above the supported number is clamped to that number.
  always_comb begin
    if (cfg_i.threshold_count > CountWidth'(MaxThresholds)) begin
      count_in_use = CountWidth'(MaxThresholds);
    end else begin
      count_in_use = cfg_i.threshold_count;
    end
  end

  assign at_active = (pin_level_i == cfg_i.active_level);

  always_comb begin
    s          = state_i;
    released   = 1'b0;
    skip_level = 1'b0;
    level_beep = 1'b0;
    alarm_beep = 1'b0;
    found      = '0;

    if (s.alarm_timer != AlarmMax) begin
      s.alarm_timer = s.alarm_timer + AlarmWidth'(1);
    end

    if (pin_level_i != state_i.last_pin_level) begin
      s.last_pin_level = pin_level_i;
      if (at_active) begin
        s.press_running = 1'b1;
        s.press_timer   = '0;
        s.level_reached = '0;
        s.max_flag      = 1'b0;
      end else if (state_i.press_running) begin
        if (state_i.press_timer != TimeMax) begin
          s.duration_hold = state_i.press_timer + TimeWidth'(1);
        end else begin
          s.duration_hold = TimeMax;
        end
        s.press_running = 1'b0;
        s.press_timer   = '0;
        released        = 1'b1;
        skip_level      = 1'b1;
      end
    end else if (state_i.press_running && at_active) begin
      if (state_i.press_timer != TimeMax) begin
        s.press_timer = state_i.press_timer + TimeWidth'(1);
      end
    end

    pressed = s.press_running && at_active;

    // Highest-numbered threshold met wins, even if the list is not ascending.
    for (int i = 0; i < MaxThresholds; i++) begin
      if ((CountWidth'(i) < count_in_use) && (s.press_timer >= cfg_i.thresholds[i])) begin
        found = LevelWidth'(i + 1);
      end
    end

    if (pressed && !skip_level) begin
      if (found > s.level_reached) begin
        s.level_reached = found;
      end
      if (s.level_reached == LevelWidth'(count_in_use)) begin
        s.max_flag = 1'b1;
      end
    end

    if (pressed) begin
      if (s.level_reached != '0) begin
        if (s.level_reached != s.last_notified_level) begin
          level_beep            = 1'b1;
          s.last_notified_level = s.level_reached;
        end
        if (s.max_flag && (s.alarm_timer >= cfg_i.alarm_interval)) begin
          alarm_beep    = 1'b1;
          s.alarm_timer = '0;
        end
      end
    end else begin
      s.last_notified_level = '0;
    end
  end

  assign state_o = s;

  always_comb begin
    result_o.pressed        = pressed;
    result_o.released       = released;
    result_o.press_duration = s.duration_hold;
    result_o.press_level    = s.level_reached;
    result_o.max_reached    = s.max_flag;
    result_o.level_beep     = level_beep;
    result_o.alarm_beep     = alarm_beep;
  end

endmodule
